// ----- sv/dynamic_error_id_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Dynamic error id allocator - assertion macros
// Shared property wrappers; the using scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_ERROR_ID_ALLOCATOR_MACROS_SVH
`define DYNAMIC_ERROR_ID_ALLOCATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DEIA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DEIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/deia_pkg.sv -----
// ----------------------------------------------------------------------------
// Dynamic error id allocator - package
// Payload types, table entry type, command and status codes.
// ----------------------------------------------------------------------------
package deia_pkg;

	localparam logic [2:0] CMD_ADD_CLASS = 3'd0;
	localparam logic [2:0] CMD_DEL_CLASS = 3'd1;
	localparam logic [2:0] CMD_ADD_CODE  = 3'd2;
	localparam logic [2:0] CMD_DEL_CODE  = 3'd3;
	localparam logic [2:0] CMD_SET_MSG   = 3'd4;
	localparam logic [2:0] CMD_DEL_MSG   = 3'd5;
	localparam logic [2:0] CMD_LOOKUP    = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADARG   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_NOIDS    = 2'd3;

	localparam logic [31:0] DYN_BIT = 32'h0000_0080;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] id_value;
		logic [31:0] message_handle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] issued_id;
		logic        has_message;
		logic [31:0] found_handle;
		logic [31:0] last_used;
	} rsp_t;

	typedef struct packed {
		logic        in_use;
		logic        msg_valid;
		logic [31:0] handle;
	} tbl_entry_t;

endpackage

// ----- sv/deia_if.sv -----
// ----------------------------------------------------------------------------
// Dynamic error id allocator - stream interfaces
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
interface deia_cmd_if;
	import deia_pkg::*;
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface deia_rsp_if;
	import deia_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/dynamic_error_id_allocator.sv -----
// ----------------------------------------------------------------------------
// Dynamic error id allocator - top level
// Issues and recycles dynamic error classes and codes, keeps one message
// handle per id.
// ----------------------------------------------------------------------------
// Each command is handled in the transfer cycle, which reads the class and code
// tables and pops the free queue, and then in the execute state, which checks,
// writes the entry back and loads the response register. The block accepts the
// next command while a response waits; the execute state stalls only while the
// response register is full and rsp.ready is low. After reset the tables are
// cleared one entry per cycle, and no command is accepted until both sweeps
// end. The floor register is written through cfg_we/cfg_wdata.
module dynamic_error_id_allocator #(
	parameter int MAX_CLASSES = 128,
	parameter int MAX_CODES   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	deia_cmd_if.sink    cmd,
	deia_rsp_if.source  rsp
);
	import deia_pkg::*;

	localparam int CW  = $clog2(MAX_CLASSES);
	localparam int IW  = $clog2(MAX_CODES);
	localparam int CCW = $clog2(MAX_CLASSES + 1);
	localparam int DCW = $clog2(MAX_CODES + 1);
	localparam logic [CCW-1:0] ClsMax  = CCW'(MAX_CLASSES);
	localparam logic [DCW-1:0] CodeMax = DCW'(MAX_CODES);
	localparam logic [7:0]     ClsLim  = 8'(MAX_CLASSES);
	localparam logic [11:0]    CodeLim = 12'(MAX_CODES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic [31:0] floor_q;
	logic started_q;
	logic [7:0] highest_q;
	logic [CCW-1:0] cls_cnt_q;
	logic [DCW-1:0] code_cnt_q;
	cmd_t item_s1;
	logic was_started_s1;
	logic cls_from_q_s1;
	logic code_from_q_s1;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept;
	logic exec_fire;
	logic cls_init_done;
	logic code_init_done;
	tbl_entry_t cls_ent;
	tbl_entry_t code_ent;
	logic cls_pop;
	logic code_pop;
	logic cls_q_empty;
	logic code_q_empty;
	logic [CW-1:0] cls_q_id;
	logic [IW-1:0] code_q_id;
	logic [CW-1:0] new_cls_id;
	logic [IW-1:0] new_code_id;

	logic cls_wr_req;
	logic code_wr_req;
	logic [CW-1:0] cls_wr_addr;
	logic [IW-1:0] code_wr_addr;
	tbl_entry_t cls_wr_data;
	tbl_entry_t code_wr_data;
	logic cls_push_req;
	logic code_push_req;
	logic cls_cnt_inc;
	logic code_cnt_inc;
	logic hi_upd;
	rsp_t rsp_d;
	logic [7:0] hi_next;

	logic [31:0] idv;
	logic upper_zero;
	logic code_sel;
	logic cls_ok;
	logic code_ok;
	logic del_cls_ok;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE) && cls_init_done && code_init_done;
	assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	assign cls_pop  = accept && (cmd.payload.command == CMD_ADD_CLASS) && !cls_q_empty;
	assign code_pop = accept && (cmd.payload.command == CMD_ADD_CODE) && !code_q_empty;

	deia_id_table #(.AW(CW)) u_cls_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (cmd.payload.id_value[CW-1:0]),
		.rd_data  (cls_ent),
		.wr_en    (exec_fire && cls_wr_req),
		.wr_addr  (cls_wr_addr),
		.wr_data  (cls_wr_data),
		.init_done(cls_init_done)
	);

	deia_id_table #(.AW(IW)) u_code_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (cmd.payload.id_value[8 +: IW]),
		.rd_data  (code_ent),
		.wr_en    (exec_fire && code_wr_req),
		.wr_addr  (code_wr_addr),
		.wr_data  (code_wr_data),
		.init_done(code_init_done)
	);

	deia_free_fifo #(.DEPTH(MAX_CLASSES), .W(CW)) u_cls_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (cls_pop),
		.push     (exec_fire && cls_push_req),
		.push_data(item_s1.id_value[CW-1:0]),
		.rd_data  (cls_q_id),
		.empty    (cls_q_empty)
	);

	deia_free_fifo #(.DEPTH(MAX_CODES), .W(IW)) u_code_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (code_pop),
		.push     (exec_fire && code_push_req),
		.push_data(item_s1.id_value[8 +: IW]),
		.rd_data  (code_q_id),
		.empty    (code_q_empty)
	);

	assign idv         = item_s1.id_value;
	assign upper_zero  = (idv[31:19] == '0);
	assign code_sel    = (idv[18:8] != '0);
	assign cls_ok      = ({1'b0, idv[6:0]} < ClsLim) && cls_ent.in_use;
	assign code_ok     = ({1'b0, idv[18:8]} < CodeLim) && code_ent.in_use;
	assign del_cls_ok  = (idv[31:8] == '0) && cls_ok;
	assign new_cls_id  = cls_from_q_s1 ? cls_q_id : cls_cnt_q[CW-1:0];
	assign new_code_id = code_from_q_s1 ? code_q_id : code_cnt_q[IW-1:0];

	always_comb begin
		rsp_d         = '0;
		cls_wr_req    = 1'b0;
		code_wr_req   = 1'b0;
		cls_wr_addr   = idv[CW-1:0];
		code_wr_addr  = idv[8 +: IW];
		cls_wr_data   = '0;
		code_wr_data  = '0;
		cls_push_req  = 1'b0;
		code_push_req = 1'b0;
		cls_cnt_inc   = 1'b0;
		code_cnt_inc  = 1'b0;
		hi_upd        = 1'b0;
		hi_next       = highest_q;
		case (item_s1.command)
			CMD_ADD_CLASS: begin
				if (cls_from_q_s1 || (cls_cnt_q < ClsMax)) begin
					cls_wr_req         = 1'b1;
					cls_wr_addr        = new_cls_id;
					cls_wr_data.in_use = 1'b1;
					rsp_d.issued_id    = 32'(new_cls_id) | DYN_BIT;
					cls_cnt_inc        = !cls_from_q_s1;
					hi_upd             = 1'b1;
				end else begin
					rsp_d.status = ST_NOIDS;
				end
			end
			CMD_DEL_CLASS: begin
				if (del_cls_ok) begin
					cls_wr_req   = 1'b1;
					cls_push_req = 1'b1;
				end else begin
					rsp_d.status = ST_NOTFOUND;
				end
			end
			CMD_ADD_CODE: begin
				if (code_from_q_s1 || (code_cnt_q < CodeMax)) begin
					code_wr_req         = 1'b1;
					code_wr_addr        = new_code_id;
					code_wr_data.in_use = 1'b1;
					rsp_d.issued_id     = idv | (32'(new_code_id) << 8);
					code_cnt_inc        = !code_from_q_s1;
				end else begin
					rsp_d.status = ST_NOIDS;
				end
			end
			CMD_DEL_CODE: begin
				if (code_ok) begin
					code_wr_req   = 1'b1;
					code_push_req = 1'b1;
				end else begin
					rsp_d.status = ST_NOTFOUND;
				end
			end
			CMD_SET_MSG: begin
				if (!was_started_s1 || !upper_zero) begin
					rsp_d.status = ST_BADARG;
				end else if (code_sel) begin
					code_wr_req            = code_ok;
					code_wr_data.in_use    = 1'b1;
					code_wr_data.msg_valid = 1'b1;
					code_wr_data.handle    = item_s1.message_handle;
				end else begin
					cls_wr_req            = cls_ok;
					cls_wr_data.in_use    = 1'b1;
					cls_wr_data.msg_valid = 1'b1;
					cls_wr_data.handle    = item_s1.message_handle;
				end
			end
			CMD_DEL_MSG: begin
				if (code_sel) begin
					code_wr_req         = code_ok;
					code_wr_data.in_use = 1'b1;
					if (!code_ok) begin
						rsp_d.status = ST_NOTFOUND;
					end
				end else begin
					cls_wr_req         = cls_ok;
					cls_wr_data.in_use = 1'b1;
					if (!cls_ok) begin
						rsp_d.status = ST_NOTFOUND;
					end
				end
			end
			CMD_LOOKUP: begin
				if (!upper_zero) begin
					rsp_d.status = ST_BADARG;
				end else if (code_sel) begin
					if (code_ok) begin
						rsp_d.has_message  = code_ent.msg_valid;
						rsp_d.found_handle = code_ent.msg_valid ? code_ent.handle : '0;
					end else begin
						rsp_d.status = ST_NOTFOUND;
					end
				end else begin
					if (cls_ok) begin
						rsp_d.has_message  = cls_ent.msg_valid;
						rsp_d.found_handle = cls_ent.msg_valid ? cls_ent.handle : '0;
					end else begin
						rsp_d.status = ST_NOTFOUND;
					end
				end
			end
			default: begin
				rsp_d.status = ST_BADARG;
			end
		endcase
		if (hi_upd && (rsp_d.issued_id[7:0] > highest_q)) begin
			hi_next = rsp_d.issued_id[7:0];
		end
		rsp_d.last_used = ({24'b0, hi_next} > floor_q) ? {24'b0, hi_next} : floor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			floor_q     <= '0;
			started_q   <= 1'b0;
			highest_q   <= '0;
			cls_cnt_q   <= CCW'(1);
			code_cnt_q  <= DCW'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				floor_q <= cfg_wdata;
			end
			if (accept && (cmd.payload.command <= CMD_DEL_MSG)) begin
				started_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_fire) begin
				highest_q <= hi_next;
				if (cls_cnt_inc) begin
					cls_cnt_q <= cls_cnt_q + 1'b1;
				end
				if (code_cnt_inc) begin
					code_cnt_q <= code_cnt_q + 1'b1;
				end
			end
			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1        <= cmd.payload;
			was_started_s1 <= started_q;
			cls_from_q_s1  <= cls_pop;
			code_from_q_s1 <= code_pop;
		end
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

`include "dynamic_error_id_allocator_macros.svh"

	`DEIA_ASSERT_NEXT(a_accept_to_exec, accept, state_q == ST_EXEC, "accept did not enter execute")
	`DEIA_ASSERT_SAME(a_cls_cnt_range, 1'b1, (cls_cnt_q != '0) && (cls_cnt_q <= ClsMax), "class counter out of range")
	`DEIA_ASSERT_SAME(a_code_cnt_range, 1'b1, (code_cnt_q != '0) && (code_cnt_q <= CodeMax), "code counter out of range")
	`DEIA_ASSERT_SAME(a_highest_dyn, highest_q != '0, highest_q[7], "highest class lacks dynamic bit")

endmodule

// ----- sv/deia_id_table.sv -----
// ----------------------------------------------------------------------------
// Dynamic error id allocator - id table
// Per-id in-use bit, message valid bit and handle in a synchronous RAM.
// Cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module deia_id_table #(
	parameter int AW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output deia_pkg::tbl_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  deia_pkg::tbl_entry_t wr_data,
	output logic                 init_done
);
	import deia_pkg::*;

	localparam int Depth = 1 << AW;

	tbl_entry_t mem_q [Depth];
	tbl_entry_t rd_data_q;
	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data   = rd_data_q;
	assign init_done = !clr_busy_q;

endmodule

// ----- sv/deia_free_fifo.sv -----
// ----------------------------------------------------------------------------
// Dynamic error id allocator - free id queue
// FIFO of released ids in a synchronous RAM; pop data is registered.
// ----------------------------------------------------------------------------
module deia_free_fifo #(
	parameter int DEPTH = 128,
	parameter int W     = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	import deia_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0]   LastIdx = AW'(DEPTH - 1);
	localparam logic [CNTW-1:0] Full    = CNTW'(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rd_data_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CNTW-1:0] count_q;
	logic push_ok;

	assign push_ok = push && (count_q != Full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
			end
			if (push_ok) begin
				tail_q <= (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
			end
			if (push_ok && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push_ok && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[tail_q] <= push_data;
		end
		if (pop) begin
			rd_data_q <= mem_q[head_q];
		end
	end

	assign rd_data = rd_data_q;
	assign empty   = (count_q == '0);

endmodule
